/* hw/rtl/assert_macros.svh */
// assertion macros for the rtl files, used by rgb_led_linear_fade_engine
// no dependencies; the including module must have i_clk and i_rst_n
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// property checked on every rising clock edge outside reset
`define ASSERT_CLK(label, prop, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) prop) \
    else $error(msg);

// implication checked on every rising clock edge outside reset
`define ASSERT_IMPL(label, ante, cons, msg) \
    `ASSERT_CLK(label, (ante) |-> (cons), msg)

`endif

/* hw/rtl/rlfe_pkg.sv */
// types, constants and command codes of the rgb led fade engine
// no dependencies; imported by rgb_led_linear_fade_engine
package rlfe_pkg;

    // number of leds and width of an led index
    localparam int LED_COUNT = 16;
    localparam int LED_W     = (LED_COUNT > 1) ? $clog2(LED_COUNT) : 1;

    // fade length = (FADE_NUM / speed) << FADE_SHIFT
    localparam logic [11:0] FADE_NUM   = 12'd4095;
    localparam int          FADE_SHIFT = 3;

    // divider step counts: fade length quotient and channel quotient
    localparam logic [3:0] DIV_STEPS_LEN = 4'd12;
    localparam logic [3:0] DIV_STEPS_CH  = 4'd8;

    // command codes
    localparam logic [1:0] CMD_SET  = 2'd0;
    localparam logic [1:0] CMD_FADE = 2'd1;
    localparam logic [1:0] CMD_TICK = 2'd2;

    // color channel selects
    localparam logic [1:0] CH_RED   = 2'd0;
    localparam logic [1:0] CH_GREEN = 2'd1;
    localparam logic [1:0] CH_BLUE  = 2'd2;

    // one color, index 0 red, 1 green, 2 blue
    typedef logic [2:0][7:0] t_rgb;

    typedef struct packed {
        logic [1:0] cmd;
        logic [7:0] led_index;
        logic [7:0] red_in;
        logic [7:0] green_in;
        logic [7:0] blue_in;
        logic [7:0] fade_speed;
    } t_in_item;

    typedef struct packed {
        logic [3:0] led_out;
        logic [7:0] red_out;
        logic [7:0] green_out;
        logic [7:0] blue_out;
        logic       updated;
        logic       last;
    } t_out_item;

    typedef enum logic [3:0] {
        S_IDLE,
        S_SET,
        S_DIV,
        S_FADE_WR,
        S_TICK_CHK,
        S_MUL,
        S_CH_WR,
        S_EMIT
    } t_state;

endpackage

/* hw/rtl/rgb_led_linear_fade_engine.sv */
// rgb led linear fade engine: per-led fade records, one shared divider under a sequencer
// depends on rlfe_pkg and assert_macros.svh
//
//  channel | signals                               | direction
//  --------+---------------------------------------+-----------
//  in      | i_in_valid, o_in_stall, i_in_item     | into block
//  out     | o_out_valid, i_out_stall, o_out_item  | from block
//
// set item: record write, then result; fade start: 12-step divide of 4095 by speed, then record write
// tick item: each led gets a check and a result; a fading led also gets multiply, 8-step divide
//   and write back for each of three channels before its result
// all division runs through one restoring divider; one item at a time
// reset clears every fade record in the reset cycle, no clearing pass
// a stalled result holds the sequencer in its emit step until taken
`include "assert_macros.svh"

module rgb_led_linear_fade_engine import rlfe_pkg::*; (
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_in_valid,
    output logic      o_in_stall,
    input  t_in_item  i_in_item,
    output logic      o_out_valid,
    input  logic      i_out_stall,
    output t_out_item o_out_item
);

    // fade records
    t_rgb        r_start [LED_COUNT];
    t_rgb        r_cur   [LED_COUNT];
    t_rgb        r_tgt   [LED_COUNT];
    logic [14:0] r_flen  [LED_COUNT];
    logic [14:0] r_fel   [LED_COUNT];

    // sequencer and datapath registers
    t_state           r_state, n_state;
    t_in_item         r_in;
    logic             r_tick;
    logic [LED_W-1:0] r_idx;
    logic [1:0]       r_ch;
    logic [14:0]      r_el;
    logic             r_neg;
    logic             r_upd;
    logic [14:0]      r_rem;
    logic [23:0]      r_dq;
    logic [14:0]      r_div;
    logic [3:0]       r_cnt;
    logic             r_out_valid;
    t_out_item        r_out;

    logic             in_acc;
    logic             emit_load;
    logic             idx_ok;
    logic             is_set;
    logic             idx_last;
    logic [15:0]      el_next;
    logic [15:0]      div_trial;
    logic             div_ge;
    logic [15:0]      div_diff;
    logic [7:0]       ch_s;
    logic [7:0]       ch_t;
    logic [7:0]       ch_mag;
    logic [22:0]      prod;
    logic [7:0]       ch_q;
    logic [7:0]       ch_v;
    logic [7:0]       idx8;

    // input decode
    assign idx_ok   = {1'b0, i_in_item.led_index} < 9'(LED_COUNT);
    assign is_set   = (i_in_item.cmd == CMD_SET)
                   || (i_in_item.cmd == CMD_FADE && i_in_item.fade_speed == 8'd0);
    assign idx_last = (r_idx == LED_W'(LED_COUNT - 1));
    assign el_next  = {1'b0, r_fel[r_idx]} + 16'd1;

    // shared divider step
    assign div_trial = {r_rem, r_dq[23]};
    assign div_ge    = div_trial >= {1'b0, r_div};
    assign div_diff  = div_trial - {1'b0, r_div};

    // channel delta magnitude and product
    assign ch_s   = r_start[r_idx][r_ch];
    assign ch_t   = r_tgt[r_idx][r_ch];
    assign ch_mag = (ch_t < ch_s) ? (ch_s - ch_t) : (ch_t - ch_s);
    assign prod   = 23'(ch_mag) * 23'(r_el);
    assign ch_q   = r_dq[7:0];
    assign ch_v   = r_neg ? (ch_s - ch_q) : (ch_s + ch_q);
    assign idx8   = 8'(r_idx);

    // handshake outputs and load strobes
    always_comb begin
        o_in_stall = (r_state != S_IDLE);
        in_acc     = i_in_valid && (r_state == S_IDLE);
        emit_load  = (r_state == S_EMIT) && (!r_out_valid || !i_out_stall);
    end

    // next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE: begin
                if (in_acc) begin
                    if (i_in_item.cmd == CMD_TICK) begin
                        n_state = S_TICK_CHK;
                    end else if ((i_in_item.cmd == CMD_SET || i_in_item.cmd == CMD_FADE)
                                 && idx_ok) begin
                        n_state = is_set ? S_SET : S_DIV;
                    end
                end
            end
            S_SET:     n_state = S_EMIT;
            S_DIV: begin
                if (r_cnt == 4'd1) begin
                    n_state = r_tick ? S_CH_WR : S_FADE_WR;
                end
            end
            S_FADE_WR: n_state = S_IDLE;
            S_TICK_CHK: begin
                if (r_flen[r_idx] == 15'd0 || el_next >= {1'b0, r_flen[r_idx]}) begin
                    n_state = S_EMIT;
                end else begin
                    n_state = S_MUL;
                end
            end
            S_MUL:     n_state = S_DIV;
            S_CH_WR:   n_state = (r_ch == CH_BLUE) ? S_EMIT : S_MUL;
            S_EMIT: begin
                if (emit_load) begin
                    n_state = (r_tick && !idx_last) ? S_TICK_CHK : S_IDLE;
                end
            end
            default:   n_state = S_IDLE;
        endcase
    end

    // state register and control
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_tick      <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= (r_out_valid && i_out_stall) || emit_load;
            if (in_acc) begin
                r_tick <= (i_in_item.cmd == CMD_TICK);
            end
        end
    end

    // fade records, cleared at reset
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < LED_COUNT; i++) begin
                r_start[i] <= '0;
                r_cur[i]   <= '0;
                r_tgt[i]   <= '0;
                r_flen[i]  <= '0;
                r_fel[i]   <= '0;
            end
        end else begin
            case (r_state)
                S_SET: begin
                    r_start[r_idx] <= {r_in.blue_in, r_in.green_in, r_in.red_in};
                    r_cur[r_idx]   <= {r_in.blue_in, r_in.green_in, r_in.red_in};
                    r_tgt[r_idx]   <= {r_in.blue_in, r_in.green_in, r_in.red_in};
                    r_flen[r_idx]  <= '0;
                end
                S_FADE_WR: begin
                    r_start[r_idx] <= r_cur[r_idx];
                    r_tgt[r_idx]   <= {r_in.blue_in, r_in.green_in, r_in.red_in};
                    r_flen[r_idx]  <= {r_dq[11:0], FADE_SHIFT'(0)};
                    r_fel[r_idx]   <= '0;
                end
                S_TICK_CHK: begin
                    if (r_flen[r_idx] != 15'd0) begin
                        if (el_next >= {1'b0, r_flen[r_idx]}) begin
                            // fade done: snap to target
                            r_fel[r_idx]  <= r_flen[r_idx];
                            r_cur[r_idx]  <= r_tgt[r_idx];
                            r_flen[r_idx] <= '0;
                        end else begin
                            r_fel[r_idx] <= el_next[14:0];
                        end
                    end
                end
                S_CH_WR: r_cur[r_idx][r_ch] <= ch_v;
                default: ;
            endcase
        end
    end

    // datapath registers
    always_ff @(posedge i_clk) begin
        case (r_state)
            S_IDLE: begin
                if (in_acc) begin
                    r_in  <= i_in_item;
                    r_idx <= (i_in_item.cmd == CMD_TICK) ? '0 : LED_W'(i_in_item.led_index);
                    // fade length quotient: 4095 / speed
                    r_rem <= '0;
                    r_dq  <= {FADE_NUM, 12'd0};
                    r_div <= {7'd0, i_in_item.fade_speed};
                    r_cnt <= DIV_STEPS_LEN;
                end
            end
            S_SET: r_upd <= 1'b1;
            S_TICK_CHK: begin
                r_upd <= (r_flen[r_idx] != 15'd0);
                r_el  <= el_next[14:0];
                r_ch  <= CH_RED;
            end
            S_MUL: begin
                // quotient stays below 256, so the top bits seed the remainder
                r_neg <= (ch_t < ch_s);
                r_rem <= prod[22:8];
                r_dq  <= {prod[7:0], 16'd0};
                r_div <= r_flen[r_idx];
                r_cnt <= DIV_STEPS_CH;
            end
            S_DIV: begin
                r_rem <= div_ge ? div_diff[14:0] : div_trial[14:0];
                r_dq  <= {r_dq[22:0], div_ge};
                r_cnt <= r_cnt - 4'd1;
            end
            S_CH_WR: r_ch <= r_ch + 2'd1;
            S_EMIT: begin
                if (emit_load) begin
                    r_out.led_out   <= idx8[3:0];
                    r_out.red_out   <= r_cur[r_idx][CH_RED];
                    r_out.green_out <= r_cur[r_idx][CH_GREEN];
                    r_out.blue_out  <= r_cur[r_idx][CH_BLUE];
                    r_out.updated   <= r_upd;
                    r_out.last      <= !r_tick || idx_last;
                    if (r_tick && !idx_last) begin
                        r_idx <= r_idx + LED_W'(1);
                    end
                end
            end
            default: ;
        endcase
    end

    assign o_out_valid = r_out_valid;
    assign o_out_item  = r_out;

    // checks
    `ASSERT_IMPL(a_busy_stalls, r_state != S_IDLE, o_in_stall,
                 "input taken while sequencer busy")
    `ASSERT_IMPL(a_load_from_emit, $rose(o_out_valid), $past(r_state) == S_EMIT,
                 "result loaded outside emit step")
    `ASSERT_IMPL(a_div_count, r_state == S_DIV, r_cnt != 4'd0,
                 "divider running with zero step count")
    `ASSERT_IMPL(a_tick_partial, o_out_valid && !o_out_item.last,
                 r_tick && r_state != S_IDLE,
                 "non-final result outside a running tick")

endmodule
